// File: rtl/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg: shared definitions for the antialiased line raster
// Widths, opcodes and the structs that pass between the front and the core.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int COORD_W   = 16;   // 12.4 endpoint coordinate
  localparam int PIX_W     = 13;   // integer pixel coordinate
  localparam int ACC_W     = 29;   // minor coordinate, 16 fraction bits
  localparam int SLOPE_W   = 18;   // slope, 16 fraction bits, range -1..1
  localparam int CHAN_W    = 8;
  localparam int COLOUR_W  = 3 * CHAN_W;
  localparam int GAP_W     = 5;    // endpoint gap, 0..16
  localparam int WGT_W     = 9;    // coverage weight, 0..256
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;
  localparam int DIV_STEPS = 32;
  localparam int DCNT_W    = 5;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // One classified request, as held in the queue between front and core.
  typedef struct packed {
    logic                      op;
    logic                      steep;
    logic signed [COORD_W-1:0] a1;
    logic signed [COORD_W-1:0] b1;
    logic signed [COORD_W-1:0] a2;
    logic signed [COORD_W-1:0] b2;
    logic [COORD_W-1:0]        dmaj;
    logic [COORD_W-1:0]        dmin_mag;
    logic                      dmin_neg;
    logic [COLOUR_W-1:0]       colour;
  } qent_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic pop;
  } core_ctl_t;

endpackage

// File: rtl/alr_if.sv
// ----------------------------------------------------------------------------
// alr_if: request and pixel channels of the antialiased line raster
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface alr_in_if;
  import alr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [CHAN_W-1:0]         red_in;
  logic [CHAN_W-1:0]         green_in;
  logic [CHAN_W-1:0]         blue_in;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, opcode, start_x, start_y, end_x, end_y,
                red_in, green_in, blue_in, output ready);
endinterface

interface alr_out_if;
  import alr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pix_x;
  logic signed [PIX_W-1:0] pix_y;
  logic [CHAN_W-1:0]       red_out;
  logic [CHAN_W-1:0]       green_out;
  logic [CHAN_W-1:0]       blue_out;
  logic                    line_last;

  modport source (output valid, pix_x, pix_y, red_out, green_out, blue_out,
                  line_last, input ready);
  modport sink (input valid, pix_x, pix_y, red_out, green_out, blue_out,
                line_last, output ready);
endinterface

// File: rtl/antialiased_line_raster.sv
// ----------------------------------------------------------------------------
// antialiased_line_raster: Wu antialiased line engine
// Turns line requests into coverage-weighted pixel transactions.
// ----------------------------------------------------------------------------
// A start transaction (opcode 0) carries two signed 12.4 endpoints and a
// colour and yields four pixels: the two nearest the first endpoint, then
// the two nearest the second, weighted by endpoint gap and coverage. Each
// step transaction (opcode 1) yields the next interior column as two pixels
// stacked across the minor axis; a step with no line in progress yields
// nothing. The last pixel of a line has line_last set. Requests pass through
// a two-entry queue, so up to two may be accepted while the core is busy.
// A step is taken from the queue in the idle state; each pixel then passes
// through a weight state and an output state, and the output state waits
// while the pixel sink stalls. A start with a nonzero major span runs the
// serial slope divider and a sign step, then the endpoint setup states EP1
// and EP2 and the emission of its four pixels; a zero-length line skips the
// divider. The divider, one quotient bit per cycle, sets the start cost;
// the shared weight multiplier sets the per-pixel cost.
module antialiased_line_raster (
  input logic       clk_i,
  input logic       rst_ni,
  alr_in_if.sink    in_i,
  alr_out_if.source out_o
);
  import alr_pkg::*;

  qent_t       ent;
  front_stat_t fstat;
  core_ctl_t   cctl;

  // Front: classify the request and hold it until the core is free.
  alr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctl_i  (cctl),
    .ent_o  (ent),
    .stat_o (fstat)
  );

  // Core: slope division, endpoint setup and pixel output register.
  alr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ent_i  (ent),
    .stat_i (fstat),
    .ctl_o  (cctl),
    .out_o  (out_o)
  );

  // The queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= QCNT_W'(QDEPTH))
    else $error("request queue overfilled");

  // The core only takes a request that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cctl.pop |-> fstat.valid)
    else $error("pop from empty request queue");

  // A pop without a simultaneous push drops the fill by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cctl.pop && !(in_i.valid && in_i.ready)) |=>
      (fstat.count == $past(fstat.count) - 1'b1))
    else $error("queue fill out of step with pops");

endmodule

// File: rtl/alr_front.sv
// ----------------------------------------------------------------------------
// alr_front: request intake and classification
// Picks the major axis, orders the endpoints and queues the request.
// ----------------------------------------------------------------------------
module alr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  alr_in_if.sink             in_i,
  input  alr_pkg::core_ctl_t ctl_i,
  output alr_pkg::qent_t     ent_o,
  output alr_pkg::front_stat_t stat_o
);
  import alr_pkg::*;

  logic signed [COORD_W:0]   dx, dy, adx, ady, dmaj, dmin;
  logic signed [COORD_W-1:0] ma1, mb1, ma2, mb2;
  logic                      steep, swap, push;
  qent_t                     ent;

  qent_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    dx    = {in_i.end_x[COORD_W-1], in_i.end_x} - {in_i.start_x[COORD_W-1], in_i.start_x};
    dy    = {in_i.end_y[COORD_W-1], in_i.end_y} - {in_i.start_y[COORD_W-1], in_i.start_y};
    adx   = dx[COORD_W] ? -dx : dx;
    ady   = dy[COORD_W] ? -dy : dy;
    steep = !(adx > ady);
    ma1   = steep ? in_i.start_y : in_i.start_x;
    mb1   = steep ? in_i.start_x : in_i.start_y;
    ma2   = steep ? in_i.end_y : in_i.end_x;
    mb2   = steep ? in_i.end_x : in_i.end_y;
    swap  = ma2 < ma1;
    ent.op     = in_i.opcode;
    ent.steep  = steep;
    ent.a1     = swap ? ma2 : ma1;
    ent.b1     = swap ? mb2 : mb1;
    ent.a2     = swap ? ma1 : ma2;
    ent.b2     = swap ? mb1 : mb2;
    dmaj = {ent.a2[COORD_W-1], ent.a2} - {ent.a1[COORD_W-1], ent.a1};
    dmin = {ent.b2[COORD_W-1], ent.b2} - {ent.b1[COORD_W-1], ent.b1};
    ent.dmaj     = dmaj[COORD_W-1:0];
    ent.dmin_neg = dmin[COORD_W];
    ent.dmin_mag = dmin[COORD_W] ? COORD_W'(-dmin) : dmin[COORD_W-1:0];
    ent.colour   = {in_i.red_in, in_i.green_in, in_i.blue_in};
  end

  assign in_i.ready = (cnt_q != QCNT_W'(QDEPTH));
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !ctl_i.pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && ctl_i.pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (ctl_i.pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= ent;
    end
  end

  assign ent_o        = mem_q[rd_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.count = cnt_q;

endmodule

// File: rtl/alr_core.sv
// ----------------------------------------------------------------------------
// alr_core: line setup and pixel emission
// Serial slope divider, endpoint setup and a pixel sequencer with weight and output states.
// ----------------------------------------------------------------------------
module alr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alr_pkg::qent_t       ent_i,
  input  alr_pkg::front_stat_t stat_i,
  output alr_pkg::core_ctl_t   ctl_o,
  alr_out_if.source            out_o
);
  import alr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SGN  = 3'd2;
  localparam logic [2:0] S_EP1  = 3'd3;
  localparam logic [2:0] S_EP2  = 3'd4;
  localparam logic [2:0] S_WGT  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  function automatic logic signed [PIX_W-1:0] ep_pm(input logic signed [COORD_W-1:0] maj);
    logic [COORD_W:0] r;
    r = {maj[COORD_W-1], maj} + (COORD_W+1)'(8);
    return r[COORD_W:4];
  endfunction

  function automatic logic [3:0] ep_low(input logic signed [COORD_W-1:0] maj);
    logic [COORD_W:0] r;
    r = {maj[COORD_W-1], maj} + (COORD_W+1)'(8);
    return r[3:0];
  endfunction

  function automatic logic [ACC_W-1:0] ep_acc(input logic signed [COORD_W-1:0] maj,
                                              input logic signed [COORD_W-1:0] mnr,
                                              input logic signed [SLOPE_W-1:0] slp);
    logic [PIX_W-1:0]   pm;
    logic [COORD_W:0]   offw;
    logic signed [4:0]  off;
    logic signed [22:0] prod;
    pm   = ep_pm(maj);
    offw = {pm, 4'b0} - {maj[COORD_W-1], maj};
    off  = offw[4:0];
    prod = slp * off;
    return {mnr[COORD_W-1], mnr, 12'b0} + {{10{prod[22]}}, prod[22:4]};
  endfunction

  logic [2:0]              state_q;
  qent_t                   cur_q;
  logic                    steep_q;
  logic [COLOUR_W-1:0]     colour_q;
  logic [SLOPE_W-1:0]      slope_q;
  logic [PIX_W-1:0]        major_pos_q, major_stop_q;
  logic [ACC_W-1:0]        minor_accum_q;
  logic                    line_active_q;
  logic [COORD_W:0]        rem_q;
  logic [COORD_W:0]        quo_q;
  logic [DCNT_W-1:0]       cnt_q;
  logic [PIX_W-1:0]        pmaj_q, e2maj_q;
  logic [ACC_W-1:0]        pacc_q, e2acc_q;
  logic [GAP_W-1:0]        pgap_q, e2gap_q;
  logic                    plast_q, e2last_q, more_q, sub_q;
  logic [WGT_W-1:0]        w_q;
  logic                    oval_q, oval_d, olast_q;
  logic [PIX_W-1:0]        ox_q, oy_q;
  logic [CHAN_W-1:0]       or_q, og_q, ob_q;

  logic                    nbit, ge;
  logic [COORD_W:0]        trial, dsub;
  logic [SLOPE_W-1:0]      qext;
  logic [PIX_W-1:0]        pm1, pm2, base, mnr, step_nx;
  logic [ACC_W-1:0]        acc1, acc2, slope_ext;
  logic [PIX_W:0]          dspan, dlast;
  logic                    none, step_last, out_free;
  logic [COORD_W:0]        f;
  logic [21:0]             pw;
  logic [16:0]             pr, pg, pb;

  assign ctl_o.pop = (state_q == S_IDLE) && stat_i.valid;

  always_comb begin
    nbit  = (cnt_q < DCNT_W'(16)) ? cur_q.dmin_mag[4'(15 - cnt_q[3:0])] : 1'b0;
    trial = {rem_q[COORD_W-1:0], nbit};
    dsub  = trial - {1'b0, cur_q.dmaj};
    ge    = !dsub[COORD_W] || trial[COORD_W];
    qext  = {1'b0, quo_q};
    slope_ext = {{(ACC_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
    pm1   = ep_pm(cur_q.a1);
    pm2   = ep_pm(cur_q.a2);
    acc1  = ep_acc(cur_q.a1, cur_q.b1, slope_q);
    acc2  = ep_acc(cur_q.a2, cur_q.b2, slope_q);
    dspan = {pm2[PIX_W-1], pm2} - {major_pos_q[PIX_W-1], major_pos_q};
    none  = dspan[PIX_W] || (dspan == '0);
    step_nx   = major_pos_q + 1'b1;
    dlast     = {step_nx[PIX_W-1], step_nx} - {major_stop_q[PIX_W-1], major_stop_q};
    step_last = !dlast[PIX_W] || (major_pos_q == 13'h0FFF);
    f     = sub_q ? {1'b0, pacc_q[15:0]} : (17'h10000 - {1'b0, pacc_q[15:0]});
    pw    = 22'(f) * 22'(pgap_q);
    base  = pacc_q[ACC_W-1:16];
    mnr   = sub_q ? base + 1'b1 : base;
    pr    = 17'(colour_q[23:16]) * 17'(w_q);
    pg    = 17'(colour_q[15:8]) * 17'(w_q);
    pb    = 17'(colour_q[7:0]) * 17'(w_q);
    out_free = !oval_q || out_o.ready;
    oval_d   = (oval_q && !out_o.ready) || ((state_q == S_OUT) && out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      steep_q       <= 1'b0;
      colour_q      <= '0;
      slope_q       <= '0;
      major_pos_q   <= '0;
      major_stop_q  <= '0;
      minor_accum_q <= '0;
      line_active_q <= 1'b0;
      more_q        <= 1'b0;
      sub_q         <= 1'b0;
      oval_q        <= 1'b0;
    end else begin
      oval_q <= oval_d;
      case (state_q)
        S_IDLE: begin
          if (stat_i.valid) begin
            if (ent_i.op == OP_START) begin
              steep_q  <= ent_i.steep;
              colour_q <= ent_i.colour;
              if (ent_i.dmaj == '0) begin
                slope_q <= '0;
                state_q <= S_EP1;
              end else begin
                state_q <= S_DIV;
              end
            end else if (line_active_q) begin
              major_pos_q   <= step_nx;
              minor_accum_q <= minor_accum_q + slope_ext;
              line_active_q <= !step_last;
              more_q        <= 1'b0;
              sub_q         <= 1'b0;
              state_q       <= S_WGT;
            end
          end
        end
        S_DIV: begin
          if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_SGN;
          end
        end
        S_SGN: begin
          slope_q <= cur_q.dmin_neg ? (~qext + SLOPE_W'(rem_q == '0)) : qext;
          state_q <= S_EP1;
        end
        S_EP1: begin
          major_pos_q   <= pm1 + 1'b1;
          minor_accum_q <= acc1 + slope_ext;
          state_q       <= S_EP2;
        end
        S_EP2: begin
          major_stop_q  <= pm2;
          line_active_q <= !none;
          more_q        <= 1'b1;
          sub_q         <= 1'b0;
          state_q       <= S_WGT;
        end
        S_WGT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (!sub_q) begin
              sub_q   <= 1'b1;
              state_q <= S_WGT;
            end else begin
              sub_q <= 1'b0;
              if (more_q) begin
                more_q  <= 1'b0;
                state_q <= S_WGT;
              end else begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (stat_i.valid) begin
          cur_q   <= ent_i;
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= '0;
          pmaj_q  <= major_pos_q;
          pacc_q  <= minor_accum_q;
          pgap_q  <= GAP_W'(16);
          plast_q <= step_last;
        end
      end
      S_DIV: begin
        cnt_q <= cnt_q + 1'b1;
        rem_q <= ge ? dsub : trial;
        quo_q <= {quo_q[COORD_W-1:0], ge};
      end
      S_EP1: begin
        pmaj_q  <= pm1;
        pacc_q  <= acc1;
        pgap_q  <= GAP_W'(16) - {1'b0, ep_low(cur_q.a1)};
        plast_q <= 1'b0;
      end
      S_EP2: begin
        e2maj_q  <= pm2;
        e2acc_q  <= acc2;
        e2gap_q  <= {1'b0, ep_low(cur_q.a2)};
        e2last_q <= none;
      end
      S_WGT: begin
        w_q <= pw[20:12];
      end
      S_OUT: begin
        if (out_free) begin
          ox_q    <= steep_q ? mnr : pmaj_q;
          oy_q    <= steep_q ? pmaj_q : mnr;
          or_q    <= pr[15:8];
          og_q    <= pg[15:8];
          ob_q    <= pb[15:8];
          olast_q <= sub_q && plast_q;
          if (sub_q && more_q) begin
            pmaj_q  <= e2maj_q;
            pacc_q  <= e2acc_q;
            pgap_q  <= e2gap_q;
            plast_q <= e2last_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid     = oval_q;
  assign out_o.pix_x     = ox_q;
  assign out_o.pix_y     = oy_q;
  assign out_o.red_out   = or_q;
  assign out_o.green_out = og_q;
  assign out_o.blue_out  = ob_q;
  assign out_o.line_last = olast_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the antialiased line raster
// Drives start and step requests through the request channel and checks
// every pixel transaction against a predictor of the Wu line algorithm.
// ----------------------------------------------------------------------------
module tb;
  import alr_pkg::*;

  // A pixel as the block reports it.
  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [CHAN_W-1:0]       r;
    logic [CHAN_W-1:0]       g;
    logic [CHAN_W-1:0]       b;
    logic                    last;
  } pixel_t;

  // One request row. The expected pixels are typed in only for rows where
  // they can be read off directly; want_fixed marks those rows.
  typedef struct {
    logic                      op;
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    logic [CHAN_W-1:0]         r, g, b;
    bit                        want_fixed;
    int                        n_fixed;
    pixel_t                    fixed [4];
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  alr_in_if  req_if ();
  alr_out_if pix_if ();

  antialiased_line_raster dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (pix_if.source)
  );

  // Predictor state, mirroring the line engine's registers.
  bit                 p_steep;
  longint             p_pos;
  longint             p_stop;
  longint             p_acc;
  longint             p_slope;
  logic [COLOUR_W-1:0] p_colour;
  bit                 p_active;

  pixel_t expected_pixels [$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     stim_done = 1'b0;

  // Floor division by a power of two: arithmetic shift does exactly this.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic pixel_t make_pixel(longint maj, longint mnr, longint w, bit last);
    pixel_t  p;
    longint  px, py;
    px = p_steep ? mnr : maj;
    py = p_steep ? maj : mnr;
    p.x = px[PIX_W-1:0];
    p.y = py[PIX_W-1:0];
    p.r = CHAN_W'((longint'(p_colour[23:16]) * w) >> 8);
    p.g = CHAN_W'((longint'(p_colour[15:8]) * w) >> 8);
    p.b = CHAN_W'((longint'(p_colour[7:0]) * w) >> 8);
    p.last = last;
    return p;
  endfunction

  // Major pixel and 16-fraction-bit minor coordinate of one endpoint.
  function automatic longint endpoint_pixel(longint maj, longint mnr, output longint acc);
    longint pm;
    pm  = floor_shr(maj + 8, 4);
    acc = mnr * 4096 + floor_shr(p_slope * (pm * 16 - maj), 4);
    return pm;
  endfunction

  function automatic void queue_endpoint(longint pm, longint acc, longint gap, bit last);
    longint fr, rf, base;
    fr   = acc & 16'hFFFF;
    rf   = 65536 - fr;
    base = floor_shr(acc, 16);
    expected_pixels.push_back(make_pixel(pm, base, (rf * gap) >> 12, 1'b0));
    expected_pixels.push_back(make_pixel(pm, base + 1, (fr * gap) >> 12, last));
  endfunction

  // Works out the pixels one accepted request causes and updates the state.
  function automatic void predict_pixels(request_t q);
    longint x1, y1, x2, y2, dx, dy, adx, ady, a1, b1, a2, b2, t;
    longint dmaj, dmin, num, quo, acc1, acc2, pm1, pm2, g1, g2;
    longint fr, base;
    bit     none, last;
    if (q.op == OP_START) begin
      x1 = q.sx; y1 = q.sy; x2 = q.ex; y2 = q.ey;
      dx = x2 - x1; dy = y2 - y1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      p_colour = {q.r, q.g, q.b};
      p_steep = !(adx > ady);
      if (p_steep) begin
        a1 = y1; b1 = x1; a2 = y2; b2 = x2;
      end else begin
        a1 = x1; b1 = y1; a2 = x2; b2 = y2;
      end
      if (a2 < a1) begin
        t = a1; a1 = a2; a2 = t;
        t = b1; b1 = b2; b2 = t;
      end
      dmaj = a2 - a1;
      dmin = b2 - b1;
      if (dmaj == 0) begin
        p_slope = 0;
      end else begin
        num = dmin * 65536;
        quo = num / dmaj;
        if (num < 0 && quo * dmaj != num) quo--;
        p_slope = quo;
      end
      pm1 = endpoint_pixel(a1, b1, acc1);
      g1  = 16 - ((a1 + 8) & 15);
      pm2 = endpoint_pixel(a2, b2, acc2);
      g2  = (a2 + 8) & 15;
      none = (pm2 - pm1) <= 1;
      queue_endpoint(pm1, acc1, g1, 1'b0);
      queue_endpoint(pm2, acc2, g2, none);
      p_pos    = pm1 + 1;
      p_stop   = pm2;
      p_acc    = acc1 + p_slope;
      p_active = !none;
    end else if (p_active) begin
      fr   = p_acc & 16'hFFFF;
      base = floor_shr(p_acc, 16);
      last = (p_pos + 1) >= p_stop;
      expected_pixels.push_back(make_pixel(p_pos, base, (65536 - fr) >> 8, 1'b0));
      expected_pixels.push_back(make_pixel(p_pos, base + 1, fr >> 8, last));
      p_acc += p_slope;
      p_pos += 1;
      if (last) p_active = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus. The directed table comes first, then random lines. Random lines
  // are mostly short, so that their interior columns are stepped through to
  // the end and a few steps run past it.
  // ---------------------------------------------------------------------------
  request_t stimulus [$];

  function automatic request_t start_req(int sx, int sy, int ex, int ey,
                                         int r, int g, int b);
    request_t q;
    q.op = OP_START;
    q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey;
    q.r = r; q.g = g; q.b = b;
    q.want_fixed = 1'b0;
    q.n_fixed = 0;
    return q;
  endfunction

  function automatic request_t step_req();
    request_t q;
    q = start_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
    q.op = OP_STEP;
    return q;
  endfunction

  function automatic pixel_t pix(int x, int y, int r, int g, int b, bit last);
    pixel_t p;
    p.x = x; p.y = y; p.r = r; p.g = g; p.b = b; p.last = last;
    return p;
  endfunction

  task automatic build_directed();
    request_t q;
    int       k;
    // A step right after reset has no line and yields nothing.
    q = step_req();
    q.want_fixed = 1'b1;
    stimulus.push_back(q);
    // Zero-length line at (0,0): y major, a half gap at both endpoints, so
    // the floor pixels get half coverage, and the last flag on pixel four.
    q = start_req(0, 0, 0, 0, 255, 255, 255);
    q.want_fixed = 1'b1;
    q.n_fixed = 4;
    q.fixed[0] = pix(0, 0, 127, 127, 127, 0);
    q.fixed[1] = pix(1, 0, 0, 0, 0, 0);
    q.fixed[2] = pix(0, 0, 127, 127, 127, 0);
    q.fixed[3] = pix(1, 0, 0, 0, 0, 1);
    stimulus.push_back(q);
    // A step after a line with no interior columns yields nothing.
    q = step_req();
    q.want_fixed = 1'b1;
    stimulus.push_back(q);
    // Extreme coordinates and colours, in both orders and on both axes.
    stimulus.push_back(start_req(-32768, -32768, 32767, 32767, 255, 0, 128));
    for (k = 0; k < 3; k++) stimulus.push_back(step_req());
    stimulus.push_back(start_req(32767, 0, -32768, 5, 1, 2, 3));
    stimulus.push_back(step_req());
    stimulus.push_back(start_req(3, 32767, -7, -32768, 0, 255, 0));
    stimulus.push_back(step_req());
    // Horizontal and vertical lines, stepped to past the end, and a 45-degree line.
    stimulus.push_back(start_req(8, 24, 72, 24, 200, 100, 50));
    for (k = 0; k < 5; k++) stimulus.push_back(step_req());
    stimulus.push_back(start_req(-20, 60, -20, -3, 0, 0, 255));
    for (k = 0; k < 5; k++) stimulus.push_back(step_req());
    stimulus.push_back(start_req(-40, 40, 37, -37, 255, 255, 255));
    stimulus.push_back(step_req());
    // A new start abandons the line above while it is still running.
    stimulus.push_back(start_req(5, -9, 1, -2, 17, 34, 51));
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535) - 32768;
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  task automatic build_random();
    int       k, steps;
    request_t q;
    while (stimulus.size() < 350) begin
      if ($urandom_range(0, 9) == 0) begin
        stimulus.push_back(step_req());
        continue;
      end
      q = start_req(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    $urandom, $urandom, $urandom);
      stimulus.push_back(q);
      steps = $urandom_range(0, 18);
      for (k = 0; k < steps; k++) stimulus.push_back(step_req());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side: bursts of random length separated by random gaps. Each
  // accepted transaction is handed to the predictor at the same edge.
  // ---------------------------------------------------------------------------
  int       req_idx = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  request_t cur_req;

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = OP_START;
    req_if.start_x = '0;
    req_if.start_y = '0;
    req_if.end_x = '0;
    req_if.end_y = '0;
    req_if.red_in = '0;
    req_if.green_in = '0;
    req_if.blue_in = '0;
    build_directed();
    build_random();
  end

  task automatic load_request(request_t q);
    req_if.valid    <= 1'b1;
    req_if.opcode   <= q.op;
    req_if.start_x  <= q.sx;
    req_if.start_y  <= q.sy;
    req_if.end_x    <= q.ex;
    req_if.end_y    <= q.ey;
    req_if.red_in   <= q.r;
    req_if.green_in <= q.g;
    req_if.blue_in  <= q.b;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        // Directed rows with typed-in results replace the predictor's output,
        // while the predictor still tracks the line state.
        if (cur_req.want_fixed) begin
          predict_pixels(cur_req);
          repeat (cur_req.n_fixed) void'(expected_pixels.pop_back());
          for (int k = 0; k < cur_req.n_fixed; k++)
            expected_pixels.push_back(cur_req.fixed[k]);
        end else begin
          predict_pixels(cur_req);
        end
        req_idx++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (req_idx >= stimulus.size()) begin
          req_if.valid <= 1'b0;
          stim_done <= 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else begin
          cur_req = stimulus[req_idx];
          load_request(cur_req);
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
          end else if (--burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side: ready follows a stall pattern that changes mode now and then,
  // including long stretches with no stalls at all.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;

  initial pix_if.ready = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: pix_if.ready <= 1'b1;
        1: pix_if.ready <= ($urandom_range(0, 3) != 0);
        2: pix_if.ready <= ($urandom_range(0, 1) != 0);
        default: pix_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Each pixel transaction is compared field by field with the oldest
  // expected pixel.
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      got = pix(pix_if.pix_x, pix_if.pix_y, pix_if.red_out, pix_if.green_out,
                pix_if.blue_out, pix_if.line_last);
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel x=%0d y=%0d rgb=%h%h%h last=%b",
                   got.x, got.y, got.r, got.g, got.b, got.last);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected x=%0d y=%0d rgb=%h%h%h last=%b, got x=%0d y=%0d rgb=%h%h%h last=%b",
                     want.x, want.y, want.r, want.g, want.b, want.last,
                     got.x, got.y, got.r, got.g, got.b, got.last);
        end
      end
    end
  end

  // Reset, then wait for the stimulus to drain and the last pixels to arrive.
  // The limit assumes every request is a start, each of its four pixels
  // stalled for a long while, plus the sender's gaps.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    // Let any stray pixel from the last step show up before the verdict.
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: antialiased_line_raster.f
rtl/alr_pkg.sv
rtl/alr_if.sv
rtl/alr_front.sv
rtl/alr_core.sv
rtl/antialiased_line_raster.sv
tb/tb.sv
